@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the gradient noise block.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GN2_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GN2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gn2_pkg.sv @@
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared constants, types and elaboration-time tables of the 2D gradient
// noise pipeline: hash weights, modular lookup tables and the sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package gn2_pkg;

  localparam int COORD_W          = 32;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int CELL_W = COORD_W - COORD_FRAC_BITS;
  localparam int LO_W   = 8;
  localparam int HI_W   = CELL_W - LO_W;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int ANG_W  = 19;
  localparam int SUM_W  = 22;
  localparam int SINE_W = 18;
  localparam int OUT_W  = 19;
  localparam int CORNERS = 4;
  localparam int GRADS   = 2 * CORNERS;

  localparam longint TWO_PI_Q16 = 411775;
  localparam longint HASH_A     = 8087142;
  localparam longint HASH_B     = 15368192;
  localparam longint HASH_C     = 22649242;
  localparam longint HASH_OFF_X = 234553;
  localparam longint HASH_OFF_Y = 380174;

  localparam longint A_MOD = HASH_A % TWO_PI_Q16;
  localparam longint B_MOD = HASH_B % TWO_PI_Q16;
  localparam longint C_MOD = HASH_C % TWO_PI_Q16;

  // The cell index is used with its sign bit inverted (offset binary); the
  // bias that this adds to every angle is folded into the offsets below.
  localparam longint CELL_BIAS = longint'(1) << (CELL_W - 1);
  localparam longint K_X = ((HASH_OFF_X - CELL_BIAS * (A_MOD + B_MOD)) % TWO_PI_Q16
                            + TWO_PI_Q16) % TWO_PI_Q16;
  localparam longint K_Y = ((HASH_OFF_Y - CELL_BIAS * (B_MOD + C_MOD)) % TWO_PI_Q16
                            + TWO_PI_Q16) % TWO_PI_Q16;

  // Reciprocal of 2*pi scaled by the table depth, for the table index.
  localparam int     RECIP_SHIFT = 32;
  localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) * SINE_TABLE_DEPTH
                                   / TWO_PI_Q16;
  localparam int     RECIP_W     = $clog2(RECIP + 1);

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned SINE_DIVS [6] = '{64'd156, 64'd110, 64'd72,
                                                64'd42, 64'd20, 64'd6};

  typedef logic [ANG_W-1:0]           ang_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic signed [SINE_W-1:0]   sine_t;
  typedef logic [GRADS-1:0][ANG_W-1:0]  ang_set_t;
  typedef logic [GRADS-1:0][SINE_W-1:0] sine_set_t;
  typedef ang_t mod_lo_t [2**LO_W];
  typedef ang_t mod_hi_t [2**HI_W];
  typedef sine_t sine_rom_t [SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
  } frac_t;

  function automatic mod_lo_t build_lo(longint w);
    mod_lo_t t;
    for (int k = 0; k < 2**LO_W; k++) begin
      t[k] = ANG_W'(((w % TWO_PI_Q16) * longint'(k)) % TWO_PI_Q16);
    end
    return t;
  endfunction

  function automatic mod_hi_t build_hi(longint w);
    mod_hi_t t;
    longint  f;
    f = ((longint'(1) << LO_W) * (w % TWO_PI_Q16)) % TWO_PI_Q16;
    for (int k = 0; k < 2**HI_W; k++) begin
      t[k] = ANG_W'((f * longint'(k)) % TWO_PI_Q16);
    end
    return t;
  endfunction

  localparam mod_lo_t A_LO = build_lo(HASH_A);
  localparam mod_hi_t A_HI = build_hi(HASH_A);
  localparam mod_lo_t B_LO = build_lo(HASH_B);
  localparam mod_hi_t B_HI = build_hi(HASH_B);
  localparam mod_lo_t C_LO = build_lo(HASH_C);
  localparam mod_hi_t C_HI = build_hi(HASH_C);

  // Brings a sum below eight times 2*pi back into [0, 2*pi).
  function automatic ang_t mod_reduce(logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    w = v;
    if (w >= SUM_W'(4 * TWO_PI_Q16)) w = w - SUM_W'(4 * TWO_PI_Q16);
    if (w >= SUM_W'(2 * TWO_PI_Q16)) w = w - SUM_W'(2 * TWO_PI_Q16);
    if (w >= SUM_W'(TWO_PI_Q16))     w = w - SUM_W'(TWO_PI_Q16);
    return ANG_W'(w);
  endfunction

  // Fraction bits of a coordinate rescaled to 16 fractional bits.
  function automatic logic [FRAC_W-1:0] frac_q16(logic [COORD_FRAC_BITS-1:0] f);
    logic [COORD_FRAC_BITS+FRAC_W-1:0] w;
    w = {f, {FRAC_W{1'b0}}} >> COORD_FRAC_BITS;
    return w[FRAC_W-1:0];
  endfunction

  // One sine entry: folded Q30 angle, odd Taylor series in Horner form.
  function automatic sine_t sine_entry(longint unsigned i);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    logic            neg;
    a   = (64'd2 * PI_Q30 * i) / SINE_TABLE_DEPTH;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x2 = (a * a) >> 30;
    t  = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / SINE_DIVS[k];
    end
    s = (((a * t) >> 30) + 64'd8192) >> 14;
    return neg ? -sine_t'(SINE_W'(s)) : sine_t'(SINE_W'(s));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      rom[i] = sine_entry(longint'(i));
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gn2_angle.sv @@
// ----------------------------------------------------------------------------
// gn2_angle
// Splits each point into cell and fraction and forms the eight hash angles
// (two per corner) reduced into [0, 2*pi), over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2_angle (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  output logic                 i_ready,
  input  logic [31:0]          i_coord_x,
  input  logic [31:0]          i_coord_z,
  output logic                 o_valid,
  input  logic                 o_ready,
  output gn2_pkg::ang_set_t    o_ang,
  output gn2_pkg::frac_t       o_frac
);

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic [gn2_pkg::CELL_W-1:0] cx_u;
  logic [gn2_pkg::CELL_W-1:0] cz_u;
  logic [gn2_pkg::LO_W-1:0]   xl, zl;
  logic [gn2_pkg::HI_W-1:0]   xh, zh;

  logic [7:0][gn2_pkg::ANG_W-1:0] lut_r;
  gn2_pkg::frac_t                 frac0_r, frac1_r, frac2_r;
  gn2_pkg::ang_t                  base_x_r, base_y_r;
  gn2_pkg::ang_set_t              ang_r;
  logic [gn2_pkg::SUM_W-1:0]      sum_x, sum_y;
  gn2_pkg::ang_set_t              ang_nxt;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Offset-binary cell index: the sign bit inverted.
  assign cx_u = {~i_coord_x[gn2_pkg::COORD_W-1],
                 i_coord_x[gn2_pkg::COORD_W-2:gn2_pkg::COORD_FRAC_BITS]};
  assign cz_u = {~i_coord_z[gn2_pkg::COORD_W-1],
                 i_coord_z[gn2_pkg::COORD_W-2:gn2_pkg::COORD_FRAC_BITS]};
  assign xl = cx_u[gn2_pkg::LO_W-1:0];
  assign zl = cz_u[gn2_pkg::LO_W-1:0];
  assign xh = cx_u[gn2_pkg::CELL_W-1:gn2_pkg::LO_W];
  assign zh = cz_u[gn2_pkg::CELL_W-1:gn2_pkg::LO_W];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lut_r[0]   <= gn2_pkg::A_HI[xh];
      lut_r[1]   <= gn2_pkg::A_LO[xl];
      lut_r[2]   <= gn2_pkg::B_HI[zh];
      lut_r[3]   <= gn2_pkg::B_LO[zl];
      lut_r[4]   <= gn2_pkg::B_HI[xh];
      lut_r[5]   <= gn2_pkg::B_LO[xl];
      lut_r[6]   <= gn2_pkg::C_HI[zh];
      lut_r[7]   <= gn2_pkg::C_LO[zl];
      frac0_r.fx <= gn2_pkg::frac_q16(i_coord_x[gn2_pkg::COORD_FRAC_BITS-1:0]);
      frac0_r.fz <= gn2_pkg::frac_q16(i_coord_z[gn2_pkg::COORD_FRAC_BITS-1:0]);
    end
  end

  assign sum_x = gn2_pkg::SUM_W'(lut_r[0]) + gn2_pkg::SUM_W'(lut_r[1])
               + gn2_pkg::SUM_W'(lut_r[2]) + gn2_pkg::SUM_W'(lut_r[3])
               + gn2_pkg::SUM_W'(gn2_pkg::K_X);
  assign sum_y = gn2_pkg::SUM_W'(lut_r[4]) + gn2_pkg::SUM_W'(lut_r[5])
               + gn2_pkg::SUM_W'(lut_r[6]) + gn2_pkg::SUM_W'(lut_r[7])
               + gn2_pkg::SUM_W'(gn2_pkg::K_Y);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      base_x_r <= gn2_pkg::mod_reduce(sum_x);
      base_y_r <= gn2_pkg::mod_reduce(sum_y);
      frac1_r  <= frac0_r;
    end
  end

  // Corner c: bit 0 steps the cell in x, bit 1 steps it in z.
  always_comb begin
    for (int c = 0; c < gn2_pkg::CORNERS; c++) begin
      ang_nxt[2*c] = gn2_pkg::mod_reduce(
          gn2_pkg::SUM_W'(base_x_r)
        + (((c & 1) != 0) ? gn2_pkg::SUM_W'(gn2_pkg::A_MOD) : '0)
        + (((c & 2) != 0) ? gn2_pkg::SUM_W'(gn2_pkg::B_MOD) : '0));
      ang_nxt[2*c+1] = gn2_pkg::mod_reduce(
          gn2_pkg::SUM_W'(base_y_r)
        + (((c & 1) != 0) ? gn2_pkg::SUM_W'(gn2_pkg::B_MOD) : '0)
        + (((c & 2) != 0) ? gn2_pkg::SUM_W'(gn2_pkg::C_MOD) : '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ang_r   <= ang_nxt;
      frac2_r <= frac1_r;
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = v_r[NS-1];
  assign o_ang   = ang_r;
  assign o_frac  = frac2_r;

endmodule

`default_nettype wire

@@ rtl/gn2_sine_rom.sv @@
// ----------------------------------------------------------------------------
// gn2_sine_rom
// One read port on the sine table, Q1.16 entries, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2_sine_rom (
  input  logic           clk,
  input  logic           en,
  input  gn2_pkg::idx_t  addr,
  output gn2_pkg::sine_t data
);

  localparam gn2_pkg::sine_rom_t SineRom = gn2_pkg::build_sine_rom();

  gn2_pkg::sine_t data_r;

  always_ff @(posedge clk) begin
    if (en) data_r <= SineRom[addr];
  end

  assign data = data_r;

endmodule

`default_nettype wire

@@ rtl/gn2_index.sv @@
// ----------------------------------------------------------------------------
// gn2_index
// Maps each reduced angle to a sine table index by a reciprocal multiply
// with a one-step correction, then reads the eight gradient components.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2_index (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  gn2_pkg::ang_set_t   i_ang,
  input  gn2_pkg::frac_t      i_frac,
  output logic                o_valid,
  input  logic                o_ready,
  output gn2_pkg::sine_set_t  o_sine,
  output gn2_pkg::frac_t      o_frac
);

  localparam int NS     = 3;
  localparam int PROD_W = gn2_pkg::ANG_W + gn2_pkg::RECIP_W;
  localparam int CMP_W  = gn2_pkg::ANG_W + gn2_pkg::IDX_W + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic [PROD_W-1:0]                  prod [gn2_pkg::GRADS];
  logic [gn2_pkg::GRADS-1:0][gn2_pkg::IDX_W-1:0] q0_r, idx_r, idx_nxt;
  gn2_pkg::ang_set_t                  r_r;
  gn2_pkg::frac_t                     frac0_r, frac1_r, frac2_r;
  logic [CMP_W-1:0]                   lhs [gn2_pkg::GRADS];
  logic [CMP_W-1:0]                   rhs [gn2_pkg::GRADS];

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // The reciprocal estimate is low by at most one.
  always_comb begin
    for (int k = 0; k < gn2_pkg::GRADS; k++) begin
      prod[k] = PROD_W'(i_ang[k]) * PROD_W'(gn2_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < gn2_pkg::GRADS; k++) begin
        q0_r[k] <= prod[k][gn2_pkg::RECIP_SHIFT +: gn2_pkg::IDX_W];
      end
      r_r     <= i_ang;
      frac0_r <= i_frac;
    end
  end

  always_comb begin
    for (int k = 0; k < gn2_pkg::GRADS; k++) begin
      lhs[k] = CMP_W'({r_r[k], {gn2_pkg::IDX_W{1'b0}}});
      rhs[k] = (CMP_W'(q0_r[k]) + CMP_W'(1)) * CMP_W'(gn2_pkg::TWO_PI_Q16);
      idx_nxt[k] = q0_r[k] + ((lhs[k] >= rhs[k]) ? gn2_pkg::IDX_W'(1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      idx_r   <= idx_nxt;
      frac1_r <= frac0_r;
    end
  end

  for (genvar g = 0; g < gn2_pkg::GRADS; g++) begin : g_rom
    gn2_sine_rom u_rom (
      .clk  (clk),
      .en   (rdy[2]),
      .addr (idx_r[g]),
      .data (o_sine[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) frac2_r <= frac1_r;
  end

  assign i_ready = rdy[0];
  assign o_valid = v_r[NS-1];
  assign o_frac  = frac2_r;

endmodule

`default_nettype wire

@@ rtl/gn2_blend.sv @@
// ----------------------------------------------------------------------------
// gn2_blend
// Dot products of the four corner gradients with their offsets, then linear
// interpolation along x and along z, over six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           i_valid,
  output logic                           i_ready,
  input  gn2_pkg::sine_set_t             i_sine,
  input  gn2_pkg::frac_t                 i_frac,
  output logic                           o_valid,
  input  logic                           o_ready,
  output logic signed [gn2_pkg::OUT_W-1:0] o_noise
);

  localparam int NS   = 6;
  localparam int OFF_W = 17;
  localparam int P_W  = gn2_pkg::SINE_W + OFF_W;
  localparam int PS_W = P_W + 1;
  localparam int D_W  = 20;
  localparam int M1_W = 38;
  localparam int L_W  = 24;
  localparam int M2_W = 41;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic signed [P_W-1:0]  p_r [gn2_pkg::CORNERS][2];
  logic signed [P_W-1:0]  p_nxt [gn2_pkg::CORNERS][2];
  logic signed [D_W-1:0]  d_r [gn2_pkg::CORNERS];
  logic signed [D_W-1:0]  d_nxt [gn2_pkg::CORNERS];
  logic signed [PS_W-1:0] psum [gn2_pkg::CORNERS];
  gn2_pkg::frac_t         frac0_r, frac1_r;
  logic [gn2_pkg::FRAC_W-1:0] fz2_r, fz3_r;
  logic signed [OFF_W-1:0] tx, tz;
  logic signed [M1_W-1:0] mb_r, mt_r;
  logic signed [D_W-1:0]  d00_r, d01_r;
  logic signed [L_W-1:0]  bot_r, top_r, bot4_r;
  logic signed [M2_W-1:0] m_r;
  logic signed [M1_W-1:0] mb_rnd, mt_rnd;
  logic signed [M2_W-1:0] m_rnd;
  logic signed [L_W-1:0]  v_full;
  logic signed [gn2_pkg::OUT_W-1:0] noise_r, noise_nxt;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Offset from a stepped corner is fraction - 1, i.e. a one on top.
  always_comb begin
    for (int c = 0; c < gn2_pkg::CORNERS; c++) begin
      p_nxt[c][0] = P_W'($signed(i_sine[2*c]))
                  * P_W'($signed({((c & 1) != 0), i_frac.fx}));
      p_nxt[c][1] = P_W'($signed(i_sine[2*c+1]))
                  * P_W'($signed({((c & 2) != 0), i_frac.fz}));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_r     <= p_nxt;
      frac0_r <= i_frac;
    end
  end

  always_comb begin
    for (int c = 0; c < gn2_pkg::CORNERS; c++) begin
      psum[c]  = PS_W'(p_r[c][0]) + PS_W'(p_r[c][1]) + PS_W'(32768);
      d_nxt[c] = D_W'(psum[c] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_r     <= d_nxt;
      frac1_r <= frac0_r;
    end
  end

  assign tx = $signed({1'b0, frac1_r.fx});

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mb_r  <= (M1_W'(d_r[1]) - M1_W'(d_r[0])) * M1_W'(tx);
      mt_r  <= (M1_W'(d_r[3]) - M1_W'(d_r[2])) * M1_W'(tx);
      d00_r <= d_r[0];
      d01_r <= d_r[2];
      fz2_r <= frac1_r.fz;
    end
  end

  assign mb_rnd = (mb_r + M1_W'(32768)) >>> 16;
  assign mt_rnd = (mt_r + M1_W'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      bot_r <= L_W'(d00_r) + L_W'(mb_rnd);
      top_r <= L_W'(d01_r) + L_W'(mt_rnd);
      fz3_r <= fz2_r;
    end
  end

  assign tz = $signed({1'b0, fz3_r});

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      m_r    <= (M2_W'(top_r) - M2_W'(bot_r)) * M2_W'(tz);
      bot4_r <= bot_r;
    end
  end

  assign m_rnd  = (m_r + M2_W'(32768)) >>> 16;
  assign v_full = bot4_r + L_W'(m_rnd);

  // Guard clamp to the Q2.16 range.
  always_comb begin
    if (v_full > L_W'(131072)) begin
      noise_nxt = gn2_pkg::OUT_W'(131072);
    end else if (v_full < -L_W'(131072)) begin
      noise_nxt = -gn2_pkg::OUT_W'(131072);
    end else begin
      noise_nxt = gn2_pkg::OUT_W'(v_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) noise_r <= noise_nxt;
  end

  assign i_ready = rdy[0];
  assign o_valid = v_r[NS-1];
  assign o_noise = noise_r;

endmodule

`default_nettype wire

@@ rtl/gradient_noise_2d.sv @@
// Throughput: one point per cycle while out_stall is low; every stage has its own
// valid bit and the stage ready chain lets bubbles close up while a result waits
// at the output.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// gradient_noise_2d
// Two-dimensional gradient noise, one Q2.16 sample per Q16.16 point, as a
// twelve-stage pipeline: angle hashing, table lookup, dot products and blend.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gradient_noise_2d (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_coord_x,
  input  logic signed [31:0]                in_coord_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gn2_pkg::OUT_W-1:0]  out_noise_value
);

  logic               ang_ready, ang_valid;
  logic               idx_ready, idx_valid;
  logic               bl_ready;
  gn2_pkg::ang_set_t  ang;
  gn2_pkg::frac_t     ang_frac, idx_frac;
  gn2_pkg::sine_set_t sine;

  gn2_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (in_valid),
    .i_ready   (ang_ready),
    .i_coord_x (in_coord_x),
    .i_coord_z (in_coord_z),
    .o_valid   (ang_valid),
    .o_ready   (idx_ready),
    .o_ang     (ang),
    .o_frac    (ang_frac)
  );

  gn2_index u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (ang_valid),
    .i_ready (idx_ready),
    .i_ang   (ang),
    .i_frac  (ang_frac),
    .o_valid (idx_valid),
    .o_ready (bl_ready),
    .o_sine  (sine),
    .o_frac  (idx_frac)
  );

  gn2_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (idx_valid),
    .i_ready (bl_ready),
    .i_sine  (sine),
    .i_frac  (idx_frac),
    .o_valid (out_valid),
    .o_ready (!out_stall),
    .o_noise (out_noise_value)
  );

  assign in_stall = !ang_ready;

  // A beat on the output is always inside the Q2.16 noise range.
  `GN2_ASSERT_IMPL(a_noise_range, out_valid, (out_noise_value <= 19'sd131072) && (out_noise_value >= -19'sd131072), "noise value out of range")
  // With the output side free, every stage can move, so input is taken.
  `GN2_ASSERT_IMPL(a_flow_through, !out_stall, !in_stall, "input stalled while output is free")
  // An empty output register leaves the whole ready chain open.
  `GN2_ASSERT_IMPL(a_empty_open, !out_valid, !in_stall, "input stalled with no result waiting")

endmodule

`default_nettype wire

@@ tb/tb_gradient_noise_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Drives points into the gradient noise pipeline under random gaps and output
// stalls, predicts each noise sample in fixed point and checks every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gradient_noise_2d;

  localparam int     FRAC_BITS   = gn2_pkg::COORD_FRAC_BITS;
  localparam int     TABLE_DEPTH = gn2_pkg::SINE_TABLE_DEPTH;
  localparam longint TWO_PI      = 411775;
  localparam longint WEIGHT_A    = 8087142;
  localparam longint WEIGHT_B    = 15368192;
  localparam longint WEIGHT_C    = 22649242;
  localparam longint BIAS_X      = 234553;
  localparam longint BIAS_Z      = 380174;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned HPI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam int     RANDOM_POINTS = 1400;
  localparam int     IDLE_LIMIT    = 5000;
  localparam int     DRAIN_CYCLES  = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_z;
  logic out_valid;
  logic out_stall;
  logic signed [gn2_pkg::OUT_W-1:0] out_noise_value;

  gradient_noise_2d u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_coord_x      (in_coord_x),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_noise_value (out_noise_value)
  );

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic               known;
    logic signed [18:0] noise;
  } point_row_t;

  longint            sine_lut [TABLE_DEPTH];
  logic signed [18:0] noise_queue [$];
  int                mismatches;
  int                idle_cycles;
  bit                hold_output;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sine_at(longint i);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned divs [6];
    bit neg;
    divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    a = (64'd2 * PI_Q30 * longint'(i)) / TABLE_DEPTH;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      a = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HPI_Q30) a = PI_Q30 - a;
    x2 = (a * a) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 6; k++) t = ONE_Q30 - ((x2 * t) >> 30) / divs[k];
    s = (((a * t) >> 30) + 64'd8192) >> 14;
    return neg ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint angle_sine(longint ang);
    longint r;
    r = ang % TWO_PI;
    if (r < 0) r += TWO_PI;
    return sine_lut[(r * TABLE_DEPTH) / TWO_PI];
  endfunction

  function automatic longint gradient_dot(longint cx, longint cz, longint dx, longint dz);
    longint gx;
    longint gz;
    gx = angle_sine(WEIGHT_A * cx + WEIGHT_B * cz + BIAS_X);
    gz = angle_sine(WEIGHT_B * cx + WEIGHT_C * cz + BIAS_Z);
    return shr_floor(gx * dx + gz * dz + 32768, 16);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + shr_floor((b - a) * t + 32768, 16);
  endfunction

  function automatic logic signed [18:0] noise_at(logic signed [31:0] px,
                                                  logic signed [31:0] pz);
    longint x;
    longint z;
    longint cx;
    longint cz;
    longint fx;
    longint fz;
    longint lo;
    longint hi;
    longint v;
    x = longint'(px);
    z = longint'(pz);
    cx = shr_floor(x, FRAC_BITS);
    cz = shr_floor(z, FRAC_BITS);
    fx = x - (cx <<< FRAC_BITS);
    fz = z - (cz <<< FRAC_BITS);
    if (FRAC_BITS >= 16) begin
      fx = fx >> (FRAC_BITS - 16);
      fz = fz >> (FRAC_BITS - 16);
    end else begin
      fx = fx << (16 - FRAC_BITS);
      fz = fz << (16 - FRAC_BITS);
    end
    lo = blend(gradient_dot(cx, cz, fx, fz), gradient_dot(cx + 1, cz, fx - 65536, fz), fx);
    hi = blend(gradient_dot(cx, cz + 1, fx, fz - 65536),
               gradient_dot(cx + 1, cz + 1, fx - 65536, fz - 65536), fx);
    v = blend(lo, hi, fz);
    if (v > 131072) v = 131072;
    if (v < -131072) v = -131072;
    return 19'(v);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Cells near the origin dominate; some points sit in the topmost cell and the rest covers the full 32-bit range.
  function automatic logic signed [31:0] random_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($signed($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    if (r < 7) return $urandom_range(0, 65535) | 32'h7FFF_0000;
    return $urandom;
  endfunction

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] z,
                            logic signed [18:0] noise);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    noise_queue.push_back(noise);
  endtask

  // Output side: random stall, one long hold-off early in the random part.
  initial begin
    int free_gap;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_output = 1'b0;
      end
      free_gap = gap_length();
      if (free_gap > 0) begin
        out_stall <= 1'b0;
        repeat (free_gap) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    logic signed [18:0] want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
      if (out_valid && !out_stall) begin
        if (noise_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: noise %0d", out_noise_value);
        end else begin
          want = noise_queue.pop_front();
          if (want !== out_noise_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("noise mismatch: expected %0d, got %0d", want, out_noise_value);
          end
        end
      end
    end
  end

  initial begin
    point_row_t rows [$];
    point_row_t row;
    int drain;
    logic signed [31:0] rx;
    logic signed [31:0] rz;
    mismatches    = 0;
    idle_cycles   = 0;
    hold_output   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) sine_lut[i] = sine_at(i);
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_coord_x <= '0;
    in_coord_z <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points: origin, cell edges, negative floors, range extremes.
    rows.push_back('{32'sh0000_0000, 32'sh0000_0000, 1'b1, 19'sd0});
    rows.push_back('{32'sh0001_0000, 32'sh0000_0000, 1'b1, 19'sd0});
    rows.push_back('{32'sh0000_0000, -32'sh0001_0000, 1'b1, 19'sd0});
    rows.push_back('{32'sh0000_8000, 32'sh0000_8000, 1'b0, 19'sd0});
    rows.push_back('{32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 19'sd0});
    rows.push_back('{32'sh0000_0001, 32'sh0000_0001, 1'b0, 19'sd0});
    rows.push_back('{-32'sh0000_0001, -32'sh0000_0001, 1'b0, 19'sd0});
    rows.push_back('{-32'sh0000_8000, 32'sh0003_4000, 1'b0, 19'sd0});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 19'sd0});
    rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 1'b0, 19'sd0});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 19'sd0});
    rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 19'sd0});
    rows.push_back('{32'sh7FFF_0000, 32'sh0000_0000, 1'b0, 19'sd0});
    rows.push_back('{32'sh8000_FFFF, 32'sh0001_FFFF, 1'b0, 19'sd0});
    rows.push_back('{32'shFFFF_FFFF, 32'shAAAA_5555, 1'b0, 19'sd0});
    rows.push_back('{32'sh5555_AAAA, 32'shFFFF_FFFF, 1'b0, 19'sd0});
    foreach (rows[i]) begin
      row = rows[i];
      send_point(row.x, row.z, row.known ? row.noise : noise_at(row.x, row.z));
    end

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n == 100) hold_output = 1'b1;
      rx = random_coord();
      rz = random_coord();
      send_point(rx, rz, noise_at(rx, rz));
    end
    in_valid <= 1'b0;

    while (noise_queue.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0 && noise_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
